// ----- rtl/qpn_pkg.sv -----
`timescale 1ns / 1ps

package qpn_pkg;

   // fixed field widths of the register file and the modulator inputs
   localparam int MOD_BITS   = 16;
   localparam int START_BITS = 17;
   localparam int DEPTH_BITS = 18;
   localparam int CSR_BITS   = 18;
   localparam int INDEX_BITS = 3;

   typedef enum logic [INDEX_BITS-1:0] {
      CSR_LAYOUT_MODE = 3'd0,
      CSR_LR_START    = 3'd1,
      CSR_LR_DEPTH    = 3'd2,
      CSR_FB_START    = 3'd3,
      CSR_FB_DEPTH    = 3'd4
   } csr_index_type;

   typedef enum logic {
      LAYOUT_AUDIO = 1'b0,
      LAYOUT_VIDEO = 1'b1
   } layout_type;

endpackage

// ----- rtl/qpn_position.sv -----
`timescale 1ns / 1ps

module qpn_position import qpn_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic        [START_BITS-1:0] start,
   input  logic signed [DEPTH_BITS-1:0] depth,
   input  logic        [MOD_BITS-1:0]   mod_val,
   output logic        [FRAC_BITS:0]    pos
);

   localparam int PROD_W = DEPTH_BITS + MOD_BITS + 1;
   localparam int SH_W   = PROD_W - MOD_BITS;
   localparam int PW     = (FRAC_BITS + 2 > SH_W + 1) ? FRAC_BITS + 2 : SH_W + 1;
   localparam logic signed [PW-1:0] ONE_P  = PW'(64'd1 << FRAC_BITS);
   localparam logic signed [PROD_W-1:0] BIAS = PROD_W'((64'd1 << MOD_BITS) - 64'd1);

   logic signed [PROD_W-1:0] prod_in, prod_ff, biased;
   logic signed [SH_W-1:0]   shifted;
   logic signed [PW-1:0]     sum_p;
   logic        [FRAC_BITS:0] pos_in, pos_ff;

   assign prod_in = PROD_W'(depth * $signed({1'b0, mod_val}));

   // divide by 2^16 toward zero: bias negatives before the arithmetic shift
   assign biased  = prod_ff + (prod_ff[PROD_W-1] ? BIAS : '0);
   assign shifted = biased[PROD_W-1:MOD_BITS];
   assign sum_p   = $signed({{(PW-START_BITS){1'b0}}, start})
                  + $signed({{(PW-SH_W){shifted[SH_W-1]}}, shifted});

   always_comb begin
      if (sum_p[PW-1]) begin
         pos_in = '0;
      end else if (sum_p > ONE_P) begin
         pos_in = ONE_P[FRAC_BITS:0];
      end else begin
         pos_in = sum_p[FRAC_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         pos_ff  <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

// ----- rtl/qpn_gains.sv -----
`timescale 1ns / 1ps

module qpn_gains import qpn_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  layout_type           mode,
   input  logic [FRAC_BITS:0]   x,
   input  logic [FRAC_BITS:0]   y,
   output logic [FRAC_BITS:0]   gain [4],
   output logic [FRAC_BITS+2:0] sum
);

   localparam int GW = FRAC_BITS + 3;
   localparam int SW = FRAC_BITS + 3;
   localparam logic signed [GW-1:0] ONE_G  = GW'(64'd1 << FRAC_BITS);
   localparam logic signed [GW-1:0] HALF_G = GW'(64'd1 << (FRAC_BITS - 1));

   logic signed [GW-1:0] xs, ys, tx, ty, dx;
   logic signed [GW-1:0] raw [4];
   logic [FRAC_BITS:0]   g_in [4];
   logic [FRAC_BITS:0]   g_c_ff [4];
   logic [FRAC_BITS:0]   g_d_ff [4];
   logic [SW-1:0]        sum_in, sum_ff;

   assign xs = $signed({2'b00, x});
   assign ys = $signed({2'b00, y});
   assign tx = (xs < HALF_G) ? xs : ONE_G - xs;
   assign ty = (ys < HALF_G) ? ys : ONE_G - ys;
   assign dx = (xs > HALF_G) ? xs - HALF_G : HALF_G - xs;

   always_comb begin
      case (mode)
         LAYOUT_AUDIO: begin
            raw[0] = (xs - HALF_G) + ty;
            raw[1] = (HALF_G - xs) + ty;
            raw[2] = (ys - HALF_G) + tx;
            raw[3] = (HALF_G - ys) + tx;
         end
         default: begin
            raw[0] = (xs <<< 1) + ys - (ONE_G <<< 1);
            raw[1] = ys - (xs <<< 1);
            raw[2] = ys - (dx <<< 1);
            raw[3] = ONE_G - ys;
         end
      endcase
   end

   // clamped gains never exceed ONE
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         g_in[i] = raw[i][GW-1] ? '0 : raw[i][FRAC_BITS:0];
      end
   end

   assign sum_in = SW'(g_c_ff[0]) + SW'(g_c_ff[1]) + SW'(g_c_ff[2]) + SW'(g_c_ff[3]);

   always_ff @(posedge clock) begin
      if (en) begin
         g_c_ff <= g_in;
         g_d_ff <= g_c_ff;
         sum_ff <= sum_in;
      end
   end

   assign gain = g_d_ff;
   assign sum  = sum_ff;

endmodule

// ----- rtl/qpn_div_lane.sv -----
`timescale 1ns / 1ps

module qpn_div_lane #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic        [SAMPLE_BITS-1:0] mag,
   input  logic                          neg,
   input  logic        [FRAC_BITS:0]     gain,
   input  logic        [FRAC_BITS+2:0]   sum,
   output logic signed [SAMPLE_BITS-1:0] result
);

   localparam int GB = FRAC_BITS + 1;
   localparam int SW = FRAC_BITS + 3;
   localparam int QB = SAMPLE_BITS;
   localparam int DW = QB + GB;

   logic [DW-1:0] prod_in;
   logic [SW-1:0] rem_ff  [QB];
   logic [QB-1:0] low_ff  [QB];
   logic [SW-1:0] sum_ff  [QB];
   logic [QB-1:0] q_ff    [QB+1];
   logic          neg_ff  [QB+1];
   logic          zero_ff [QB+1];
   logic signed [QB-1:0] res_in, res_ff;

   assign prod_in = DW'(mag * gain);

   // quotient fits in QB bits, so the high part of the product starts below sum
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= {{(SW-GB){1'b0}}, prod_in[DW-1:QB]};
         low_ff[0]  <= prod_in[QB-1:0];
         sum_ff[0]  <= sum;
         q_ff[0]    <= '0;
         neg_ff[0]  <= neg;
         zero_ff[0] <= (sum == '0);
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [SW:0] t_in;
      logic        ge_in;

      assign t_in  = {rem_ff[k], low_ff[k][QB-1]};
      assign ge_in = (t_in >= {1'b0, sum_ff[k]});

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k+1]    <= {q_ff[k][QB-2:0], ge_in};
            neg_ff[k+1]  <= neg_ff[k];
            zero_ff[k+1] <= zero_ff[k];
         end
      end

      if (k < QB - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= ge_in ? SW'(t_in - {1'b0, sum_ff[k]}) : t_in[SW-1:0];
               low_ff[k+1] <= {low_ff[k][QB-2:0], 1'b0};
               sum_ff[k+1] <= sum_ff[k];
            end
         end
      end
   end

   always_comb begin
      if (zero_ff[QB]) begin
         res_in = '0;
      end else if (neg_ff[QB]) begin
         res_in = $signed(-q_ff[QB]);
      end else begin
         res_in = $signed(q_ff[QB]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// ----- rtl/quad_panner_normalised_top.sv -----
`timescale 1ns / 1ps

// channel  | ports                                   | transfer
// ---------+-----------------------------------------+-------------------------
// request  | req_valid req_ready req_sample_in/mod_* | beat on valid & ready
// response | rsp_valid rsp_ready rsp_out_*           | beat on valid & ready
// csr      | csr_wr_en csr_index csr_wdata           | write on csr_wr_en
//
// One beat per cycle sustained while responses are taken; the four output lanes
// each divide with a one-bit-per-stage divider.
// Synchronous reset clears the valid chain and restores the register defaults.
// When the response beat is held, the whole pipeline freezes and req_ready drops.

module quad_panner_normalised_top import qpn_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic        [MOD_BITS-1:0]    req_mod_lr,
   input  logic        [MOD_BITS-1:0]    req_mod_fb,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_right,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_front,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_back,
   input  logic                          csr_wr_en,
   input  logic        [INDEX_BITS-1:0]  csr_index,
   input  logic        [CSR_BITS-1:0]    csr_wdata
);

   localparam int LAT = SAMPLE_BITS + 6;

   layout_type                   layout_mode_ff;
   logic        [START_BITS-1:0] lr_start_ff, fb_start_ff;
   logic signed [DEPTH_BITS-1:0] lr_depth_ff, fb_depth_ff;

   logic                          advance;
   logic        [LAT-1:0]         valid_ff;
   logic signed [SAMPLE_BITS-1:0] samp_a_ff, samp_b_ff, samp_c_ff;
   logic        [SAMPLE_BITS-1:0] mag_in, mag_d_ff;
   logic                          neg_d_ff;
   logic        [FRAC_BITS:0]     pos_x, pos_y;
   logic        [FRAC_BITS:0]     gain [4];
   logic        [FRAC_BITS+2:0]   gain_sum;
   logic signed [SAMPLE_BITS-1:0] lane_res [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_mode_ff <= LAYOUT_AUDIO;
         lr_start_ff    <= START_BITS'(32768);
         lr_depth_ff    <= '0;
         fb_start_ff    <= START_BITS'(32768);
         fb_depth_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LAYOUT_MODE: layout_mode_ff <= layout_type'(csr_wdata[0]);
            CSR_LR_START:    lr_start_ff    <= csr_wdata[START_BITS-1:0];
            CSR_LR_DEPTH:    lr_depth_ff    <= $signed(csr_wdata[DEPTH_BITS-1:0]);
            CSR_FB_START:    fb_start_ff    <= csr_wdata[START_BITS-1:0];
            CSR_FB_DEPTH:    fb_depth_ff    <= $signed(csr_wdata[DEPTH_BITS-1:0]);
            default: ;
         endcase
      end
   end

   assign advance   = !valid_ff[LAT-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[LAT-2:0], req_valid};
      end
   end

   // magnitude of the most negative sample still fits unsigned
   assign mag_in = samp_c_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-samp_c_ff) : samp_c_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         samp_a_ff <= req_sample_in;
         samp_b_ff <= samp_a_ff;
         samp_c_ff <= samp_b_ff;
         mag_d_ff  <= mag_in;
         neg_d_ff  <= samp_c_ff[SAMPLE_BITS-1];
      end
   end

   qpn_position #(.FRAC_BITS(FRAC_BITS)) u_pos_lr (
      .clock   (clock),
      .en      (advance),
      .start   (lr_start_ff),
      .depth   (lr_depth_ff),
      .mod_val (req_mod_lr),
      .pos     (pos_x)
   );

   qpn_position #(.FRAC_BITS(FRAC_BITS)) u_pos_fb (
      .clock   (clock),
      .en      (advance),
      .start   (fb_start_ff),
      .depth   (fb_depth_ff),
      .mod_val (req_mod_fb),
      .pos     (pos_y)
   );

   qpn_gains #(.FRAC_BITS(FRAC_BITS)) u_gains (
      .clock (clock),
      .en    (advance),
      .mode  (layout_mode_ff),
      .x     (pos_x),
      .y     (pos_y),
      .gain  (gain),
      .sum   (gain_sum)
   );

   for (genvar i = 0; i < 4; i++) begin : g_lane
      qpn_div_lane #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .FRAC_BITS   (FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .en     (advance),
         .mag    (mag_d_ff),
         .neg    (neg_d_ff),
         .gain   (gain[i]),
         .sum    (gain_sum),
         .result (lane_res[i])
      );
   end

   assign rsp_out_left  = lane_res[0];
   assign rsp_out_right = lane_res[1];
   assign rsp_out_front = lane_res[2];
   assign rsp_out_back  = lane_res[3];

endmodule

// ----- tb/tb_quad_panner_normalised_top.sv -----
`timescale 1ns / 1ps

module tb_quad_panner_normalised_top;
   import qpn_pkg::*;

   localparam int     SAMPLE_BITS = 16;
   localparam longint ONE         = 65536;
   localparam longint HALF        = ONE / 2;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [MOD_BITS-1:0]           mod_lr;
      logic [MOD_BITS-1:0]           mod_fb;
   } pan_req_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic signed [SAMPLE_BITS-1:0] front;
      logic signed [SAMPLE_BITS-1:0] back;
   } speaker_mix_type;

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample_in = '0;
   logic        [MOD_BITS-1:0]    req_mod_lr    = '0;
   logic        [MOD_BITS-1:0]    req_mod_fb    = '0;
   logic                          rsp_valid;
   logic                          rsp_ready     = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_out_left;
   logic signed [SAMPLE_BITS-1:0] rsp_out_right;
   logic signed [SAMPLE_BITS-1:0] rsp_out_front;
   logic signed [SAMPLE_BITS-1:0] rsp_out_back;
   logic                          csr_wr_en     = 1'b0;
   logic        [INDEX_BITS-1:0]  csr_index     = '0;
   logic        [CSR_BITS-1:0]    csr_wdata     = '0;

   // register shadow
   layout_type layout_q   = LAYOUT_AUDIO;
   longint     lr_start_q = 32768;
   longint     lr_depth_q = 0;
   longint     fb_start_q = 32768;
   longint     fb_depth_q = 0;

   pan_req_type     pan_pending[$];
   speaker_mix_type mix_expected[$];
   pan_req_type     next_beat;
   speaker_mix_type want;
   int              send_gap   = 0;
   int              stall_cnt  = 0;
   int              mismatches = 0;
   bit              calm       = 1'b0;

   quad_panner_normalised_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .req_mod_lr    (req_mod_lr),
      .req_mod_fb    (req_mod_fb),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_left  (rsp_out_left),
      .rsp_out_right (rsp_out_right),
      .rsp_out_front (rsp_out_front),
      .rsp_out_back  (rsp_out_back),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // position: start plus depth*mod/2^16 (toward zero), saturated to 0..ONE
   function automatic longint place(longint start, longint depth, logic [MOD_BITS-1:0] m);
      longint p;
      p = start + (depth * longint'(m)) / 65536;
      if (p < 0)
         p = 0;
      if (p > ONE)
         p = ONE;
      return p;
   endfunction

   function automatic longint clip_neg(longint g);
      return (g < 0) ? 0 : g;
   endfunction

   function automatic speaker_mix_type mix_speakers(logic signed [SAMPLE_BITS-1:0] smp,
                                                    logic [MOD_BITS-1:0] mlr,
                                                    logic [MOD_BITS-1:0] mfb);
      speaker_mix_type m;
      longint x, y, tx, ty, d, gl, gr, gf, gb, sum, s;
      x = place(lr_start_q, lr_depth_q, mlr);
      y = place(fb_start_q, fb_depth_q, mfb);
      if (layout_q == LAYOUT_AUDIO) begin
         ty = (y < HALF) ? y : ONE - y;
         tx = (x < HALF) ? x : ONE - x;
         gl = clip_neg((x - HALF) + ty);
         gr = clip_neg((HALF - x) + ty);
         gf = clip_neg((y - HALF) + tx);
         gb = clip_neg((HALF - y) + tx);
      end else begin
         d  = (x > HALF) ? x - HALF : HALF - x;
         gl = clip_neg(2 * x + y - 2 * ONE);
         gr = clip_neg(y - 2 * x);
         gf = clip_neg(y - 2 * d);
         gb = clip_neg(ONE - y);
      end
      sum = gl + gr + gf + gb;
      s   = longint'(smp);
      if (sum <= 0) begin
         m.left  = '0;
         m.right = '0;
         m.front = '0;
         m.back  = '0;
      end else begin
         m.left  = SAMPLE_BITS'((s * gl) / sum);
         m.right = SAMPLE_BITS'((s * gr) / sum);
         m.front = SAMPLE_BITS'((s * gf) / sum);
         m.back  = SAMPLE_BITS'((s * gb) / sum);
      end
      return m;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic logic [CSR_BITS-1:0] pick_start();
      logic [CSR_BITS-1:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = CSR_BITS'(ONE);
         2: v = CSR_BITS'(HALF);
         3: v = CSR_BITS'($urandom_range(ONE + 1, 131071));
         default: v = CSR_BITS'($urandom_range(0, ONE));
      endcase
      // top bit lies outside the 17-bit register
      if ($urandom_range(0, 7) == 0)
         v[CSR_BITS-1] = 1'b1;
      return v;
   endfunction

   function automatic logic [CSR_BITS-1:0] pick_depth();
      int v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = int'(ONE);
         2: v = int'(-ONE);
         3: v = int'($urandom());
         4: v = int'($urandom_range(0, 2048)) - 1024;
         default: v = int'($urandom_range(0, 2 * ONE) - ONE);
      endcase
      return v[CSR_BITS-1:0];
   endfunction

   task automatic write_reg(csr_index_type idx, logic [CSR_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_LAYOUT_MODE: layout_q   = layout_type'(data[0]);
         CSR_LR_START:    lr_start_q = longint'(data[START_BITS-1:0]);
         CSR_LR_DEPTH:    lr_depth_q = longint'($signed(data[DEPTH_BITS-1:0]));
         CSR_FB_START:    fb_start_q = longint'(data[START_BITS-1:0]);
         CSR_FB_DEPTH:    fb_depth_q = longint'($signed(data[DEPTH_BITS-1:0]));
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_req(int smp, int mlr, int mfb);
      pan_req_type b;
      b.sample = SAMPLE_BITS'(smp);
      b.mod_lr = MOD_BITS'(mlr);
      b.mod_fb = MOD_BITS'(mfb);
      pan_pending.push_back(b);
   endtask

   task automatic drain();
      while (pan_pending.size() != 0 || mix_expected.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   task automatic check_field(string name, logic signed [SAMPLE_BITS-1:0] exp_v,
                              logic signed [SAMPLE_BITS-1:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
         mismatches++;
      end
   endtask

   // stretches with no idling on either side
   always @(posedge clock) begin
      if ($urandom_range(0, 149) == 0)
         calm <= !calm;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid)
            mix_expected.push_back(mix_speakers(req_sample_in, req_mod_lr, req_mod_fb));
         if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pan_pending.size() != 0) begin
            next_beat = pan_pending.pop_front();
            req_sample_in <= next_beat.sample;
            req_mod_lr    <= next_beat.mod_lr;
            req_mod_fb    <= next_beat.mod_fb;
            req_valid     <= 1'b1;
            send_gap      <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_cnt <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (mix_expected.size() == 0) begin
               $error("response beat with nothing outstanding");
               mismatches++;
            end else begin
               want = mix_expected.pop_front();
               check_field("out_left",  want.left,  rsp_out_left);
               check_field("out_right", want.right, rsp_out_right);
               check_field("out_front", want.front, rsp_out_front);
               check_field("out_back",  want.back,  rsp_out_back);
            end
         end
         if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
               stall_cnt <= pick_gap();
         end
      end
   end

   initial begin
      int corner_samples[4];
      int corner_mods[3];
      int ph, i, smp, mlr, mfb;
      corner_samples = '{-32768, 32767, 0, -1};
      corner_mods    = '{0, 65535, 32768};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // register defaults: centered image
      queue_req(32767, 0, 65535);
      queue_req(-32768, 65535, 0);
      queue_req(0, 21845, 43690);
      queue_req(-1, 1, 1);
      drain();

      // full sweep, x ~ 2*mod_lr and y ~ 2*mod_fb, both layouts
      write_reg(CSR_LR_START, '0);
      write_reg(CSR_LR_DEPTH, 18'h1FFFF);
      write_reg(CSR_FB_START, '0);
      write_reg(CSR_FB_DEPTH, 18'h1FFFF);
      for (ph = 0; ph < 2; ph++) begin
         write_reg(CSR_LAYOUT_MODE, CSR_BITS'((ph == 0) ? LAYOUT_AUDIO : LAYOUT_VIDEO));
         queue_req(32767, 0, 0);
         queue_req(-32768, 0, 65535);
         queue_req(32767, 65535, 0);
         queue_req(-32768, 65535, 65535);
         queue_req(12345, 16384, 32768);
         drain();
      end

      // start beyond full scale with most negative depth; negative saturation on fb
      write_reg(CSR_LR_START, 18'h1FFFF);
      write_reg(CSR_LR_DEPTH, 18'h20000);
      write_reg(CSR_FB_START, '0);
      write_reg(CSR_FB_DEPTH, 18'h20000);
      queue_req(32767, 0, 65535);
      queue_req(-32768, 65535, 0);
      queue_req(-20000, 32768, 32768);
      drain();

      for (ph = 0; ph < 8; ph++) begin
         // odd upper bits on the mode write are ignored by the block
         write_reg(CSR_LAYOUT_MODE, CSR_BITS'($urandom()));
         write_reg(CSR_LR_START, pick_start());
         write_reg(CSR_LR_DEPTH, pick_depth());
         write_reg(CSR_FB_START, pick_start());
         write_reg(CSR_FB_DEPTH, pick_depth());
         for (i = 0; i < 90; i++) begin
            smp = ($urandom_range(0, 9) == 0) ? corner_samples[$urandom_range(0, 3)]
                                              : int'($urandom());
            mlr = ($urandom_range(0, 9) == 0) ? corner_mods[$urandom_range(0, 2)]
                                              : int'($urandom());
            mfb = ($urandom_range(0, 9) == 0) ? corner_mods[$urandom_range(0, 2)]
                                              : int'($urandom());
            queue_req(smp, mlr, mfb);
         end
         drain();
      end

      // catch any stray beat past the pipeline depth
      repeat (SAMPLE_BITS + 16) @(posedge clock);
      if (mismatches == 0 && mix_expected.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
